// File: rtl/handheld_console_timer_macros.svh
// ----------------------------------------------------------------------------
// handheld_console_timer_macros
// Assertion macros shared by the timer RTL. Each macro expects clk and rst_n
// to exist in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_CONSOLE_TIMER_MACROS_SVH
`define HANDHELD_CONSOLE_TIMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hct_pkg.sv
// ----------------------------------------------------------------------------
// hct_pkg
// Shared types and constants of the divider and timer block.
// ----------------------------------------------------------------------------
package hct_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_TIMER_ENABLE = 2'd0;
    localparam logic [1:0] REG_CLOCK_SELECT = 2'd1;
    localparam logic [1:0] REG_RELOAD_VALUE = 2'd2;

    // Clock select codes.
    localparam logic [1:0] SEL_4096   = 2'd0;
    localparam logic [1:0] SEL_262144 = 2'd1;
    localparam logic [1:0] SEL_65536  = 2'd2;
    localparam logic [1:0] SEL_16384  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // request accepted: advance divider, set up the walk
        logic step;      // walk one machine cycle
        logic load_out;  // copy the final state into the output registers
    } hct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done; // no machine cycles left to walk
    } hct_status_t;

    // Divider bit watched for the selected rate.
    function automatic logic tap_bit(input logic [15:0] div, input logic [1:0] sel);
        logic bit_val;
        case (sel)
            SEL_4096:   bit_val = div[9];
            SEL_262144: bit_val = div[3];
            SEL_65536:  bit_val = div[5];
            SEL_16384:  bit_val = div[7];
            default:    bit_val = div[9];
        endcase
        return bit_val;
    endfunction

endpackage

// File: rtl/hct_datapath.sv
// ----------------------------------------------------------------------------
// hct_datapath
// Divider, timer counter, walk counter, configuration and output registers.
// ----------------------------------------------------------------------------
module hct_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic [7:0]          cycle_count,
    input  hct_pkg::hct_cmd_t   cmd,
    output hct_pkg::hct_status_t status,
    output logic [7:0]          divider_value,
    output logic [7:0]          divider_low,
    output logic [7:0]          timer_count,
    output logic                interrupt_raised
);
    import hct_pkg::*;

    logic        enable_reg;
    logic [1:0]  select_reg;
    logic [7:0]  reload_reg;
    logic [15:0] div_reg;
    logic [7:0]  counter_reg;
    logic        running_reg;
    logic        last_pulse_reg;
    logic        pending_reg;
    logic        irq_reg;
    logic [15:0] walk_clk_reg;
    logic [7:0]  remain_reg;
    logic [7:0]  div_hi_out_reg;
    logic [7:0]  div_lo_out_reg;
    logic [7:0]  count_out_reg;
    logic        irq_out_reg;

    logic [15:0] div_next;
    logic [15:0] walk_clk_next;
    logic [7:0]  base_count;
    logic [7:0]  inc_count;
    logic        pulse;
    logic        falling;

    // Divider value at the end of this request.
    assign div_next = div_reg + {8'd0, cycle_count};

    // One walked machine cycle: reload a pending overflow, then look for a falling edge.
    assign walk_clk_next = walk_clk_reg + 16'd1;
    assign pulse         = tap_bit(walk_clk_next, select_reg);
    assign falling       = last_pulse_reg && !pulse;
    assign base_count    = pending_reg ? reload_reg : counter_reg;
    assign inc_count     = base_count + 8'd1;

    assign status.walk_done = (remain_reg == 8'd0);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            select_reg <= 2'd0;
            reload_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMER_ENABLE: enable_reg <= cfg_data[0];
                REG_CLOCK_SELECT: select_reg <= cfg_data[1:0];
                REG_RELOAD_VALUE: reload_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Timer state and walk bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg        <= 16'd0;
            counter_reg    <= 8'd0;
            running_reg    <= 1'b0;
            last_pulse_reg <= 1'b0;
            pending_reg    <= 1'b0;
            irq_reg        <= 1'b0;
            walk_clk_reg   <= 16'd0;
            remain_reg     <= 8'd0;
        end
        else if (cmd.start)
        begin
            div_reg     <= div_next;
            running_reg <= enable_reg;
            irq_reg     <= 1'b0;
            if (enable_reg && !running_reg)
            begin
                // First enabled request walks only the cycle at the new divider value.
                walk_clk_reg <= div_next - 16'd1;
                remain_reg   <= 8'd1;
            end
            else if (enable_reg)
            begin
                walk_clk_reg <= div_reg;
                remain_reg   <= cycle_count;
            end
            else
            begin
                remain_reg <= 8'd0;
            end
        end
        else if (cmd.step)
        begin
            walk_clk_reg   <= walk_clk_next;
            remain_reg     <= remain_reg - 8'd1;
            last_pulse_reg <= pulse;
            irq_reg        <= irq_reg | pending_reg;
            counter_reg    <= falling ? inc_count : base_count;
            pending_reg    <= falling && (inc_count == 8'd0);
        end
    end

    // Output registers, loaded only when the previous result has been taken.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            div_hi_out_reg <= div_reg[15:8];
            div_lo_out_reg <= div_reg[7:0];
            count_out_reg  <= counter_reg;
            irq_out_reg    <= irq_reg;
        end
    end

    assign divider_value    = div_hi_out_reg;
    assign divider_low      = div_lo_out_reg;
    assign timer_count      = count_out_reg;
    assign interrupt_raised = irq_out_reg;

endmodule

// File: rtl/hct_controller.sv
// ----------------------------------------------------------------------------
// hct_controller
// Sequencer that accepts a request, steps the walk and hands off the result.
// ----------------------------------------------------------------------------
`include "handheld_console_timer_macros.svh"

module hct_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  hct_pkg::hct_status_t status,
    output hct_pkg::hct_cmd_t    cmd
);
    import hct_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Commands to the datapath.
    assign cmd.start    = accept;
    assign cmd.step     = (state_reg == ST_WALK) && !status.walk_done;
    assign cmd.load_out = (state_reg == ST_FINISH) && out_free;

    // Next state and output valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new request always starts a walk.
    `HCT_ASSERT_NEXT(a_accept_walk, accept, state_reg == ST_WALK, "request did not start a walk")
    // A finished walk with a free output register always delivers a result.
    `HCT_ASSERT_NEXT(a_finish_out, cmd.load_out, out_valid_reg && state_reg == ST_IDLE,
        "finished result was not presented")
    // Stepping and starting never overlap.
    `HCT_ASSERT_SAME(a_no_overlap, cmd.step, !cmd.start && !cmd.load_out,
        "walk step overlapped another command")

endmodule

// File: rtl/handheld_console_timer.sv
// ----------------------------------------------------------------------------
// handheld_console_timer
// Free-running 16-bit divider with a programmable 8-bit timer and interrupt.
// ----------------------------------------------------------------------------
// Each request adds cycle_count machine cycles to the divider. While the timer
// is enabled the block walks those cycles one per clock. It accepts the
// request, walks each cycle, sees the walk end and hands the result to the
// output register; a disabled timer walks no cycles, and the first request
// after enabling walks only the last one. The walk counter in the datapath
// holds the cycles left to walk. The next request is accepted as soon as the
// result sits in the output register, even while that result is stalled.
module handheld_console_timer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] cycle_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] divider_value,
    output logic [7:0] divider_low,
    output logic [7:0] timer_count,
    output logic       interrupt_raised
);
    import hct_pkg::*;

    hct_cmd_t    cmd;
    hct_status_t status;

    // Sequencer.
    hct_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Divider, counter and result registers.
    hct_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cycle_count      (cycle_count),
        .cmd              (cmd),
        .status           (status),
        .divider_value    (divider_value),
        .divider_low      (divider_low),
        .timer_count      (timer_count),
        .interrupt_raised (interrupt_raised)
    );

endmodule

// File: test/handheld_console_timer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handheld_console_timer_tb
// Self-checking bench for the divider and timer block. A short directed plan
// covers the register extremes, the first step after enabling, zero-cycle
// requests, divider wrap and repeated overflow. Random phases follow, each with
// a fresh register setting. Every result is checked against plan values or an
// in-bench model of the divider, the counter and the overflow reload.
// ----------------------------------------------------------------------------
module handheld_console_timer_tb;
    import hct_pkg::*;

    localparam int         RANDOM_ITEMS = 1040;
    localparam int         CYCLE_LIMIT  = 3000000;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [7:0] div_hi;
        logic [7:0] div_lo;
        logic [7:0] count;
        logic       irq;
    } timer_result_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [1:0]    index;
        logic [7:0]    data;
        logic [9:0]    reps;
        logic          typed;
        timer_result_t want;
    } plan_row_t;

    // Directed plan. Config rows write index/data; request rows send data reps times.
    localparam int PLAN_ROWS = 23;
    plan_row_t plan [0:PLAN_ROWS-1] = '{
        '{ROW_ITEM, 2'd0, 8'h00, 10'd1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{ROW_ITEM, 2'd0, 8'hFF, 10'd1, 1'b1, '{8'h00, 8'hFF, 8'h00, 1'b0}},
        '{ROW_ITEM, 2'd0, 8'h01, 10'd1, 1'b1, '{8'h01, 8'h00, 8'h00, 1'b0}},
        '{ROW_CFG, REG_UNUSED, 8'hFF, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'hFF, 10'd260, 1'b0, '0},
        '{ROW_CFG, REG_CLOCK_SELECT, 8'hFD, 10'd1, 1'b0, '0},
        '{ROW_CFG, REG_RELOAD_VALUE, 8'hFF, 10'd1, 1'b0, '0},
        '{ROW_CFG, REG_TIMER_ENABLE, 8'hFF, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'h00, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'h00, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'hFF, 10'd20, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'h07, 10'd12, 1'b0, '0},
        '{ROW_CFG, REG_TIMER_ENABLE, 8'h00, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'h64, 10'd1, 1'b0, '0},
        '{ROW_CFG, REG_CLOCK_SELECT, {6'd0, SEL_16384}, 10'd1, 1'b0, '0},
        '{ROW_CFG, REG_RELOAD_VALUE, 8'h00, 10'd1, 1'b0, '0},
        '{ROW_CFG, REG_TIMER_ENABLE, 8'h01, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'hFF, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'hFF, 10'd40, 1'b0, '0},
        '{ROW_CFG, REG_CLOCK_SELECT, {6'd0, SEL_4096}, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'hFF, 10'd40, 1'b0, '0},
        '{ROW_CFG, REG_CLOCK_SELECT, {6'd0, SEL_65536}, 10'd1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'h80, 10'd30, 1'b0, '0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_TIMER_ENABLE;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] cycle_count = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] divider_value;
    logic [7:0] divider_low;
    logic [7:0] timer_count;
    logic       interrupt_raised;

    // Model state and register copies.
    logic [15:0] model_divider = 16'd0;
    logic [7:0]  model_counter = 8'd0;
    logic        model_running = 1'b0;
    logic        model_last_tap = 1'b0;
    logic        model_overflow = 1'b0;
    logic        reg_enable = 1'b0;
    logic [1:0]  reg_select = SEL_4096;
    logic [7:0]  reg_reload = 8'd0;

    timer_result_t pending_results [$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            clock_ticks = 0;
    int            gap_max = 7;
    int            stall_max = 7;

    handheld_console_timer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cycle_count      (cycle_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .divider_value    (divider_value),
        .divider_low      (divider_low),
        .timer_count      (timer_count),
        .interrupt_raised (interrupt_raised)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        clock_ticks <= clock_ticks + 1;
        if (clock_ticks > CYCLE_LIMIT)
        begin
            $display("handheld_console_timer_tb: FAIL");
            $finish;
        end
    end

    // Advance the divider by the request's cycles and walk the timer.
    task automatic advance_timer(input logic [7:0] cycles, output timer_result_t res);
        logic [15:0] base;
        logic [15:0] now_div;
        logic [15:0] div_at;
        logic        tap;
        logic        irq;
        int          last_walk;
        int          i;
        base = model_divider;
        now_div = model_divider + {8'd0, cycles};
        irq = 1'b0;
        last_walk = int'(cycles);
        model_divider = now_div;
        if (!reg_enable)
        begin
            model_running = 1'b0;
        end
        else
        begin
            // The first enabled request only looks at the final cycle.
            if (!model_running)
            begin
                model_running = 1'b1;
                base = now_div - 16'd1;
                last_walk = 1;
            end
            for (i = 1; i <= last_walk; i++)
            begin
                div_at = base + i[15:0];
                if (model_overflow)
                begin
                    model_overflow = 1'b0;
                    model_counter = reg_reload;
                    irq = 1'b1;
                end
                case (reg_select)
                    SEL_262144: tap = div_at[3];
                    SEL_65536:  tap = div_at[5];
                    SEL_16384:  tap = div_at[7];
                    default:    tap = div_at[9];
                endcase
                if (model_last_tap && !tap)
                begin
                    model_counter = model_counter + 8'd1;
                    model_overflow = (model_counter == 8'd0);
                end
                model_last_tap = tap;
            end
        end
        res = '{now_div[15:8], now_div[7:0], model_counter, irq};
    endtask

    // Register write; the model sees only the implemented bits.
    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            REG_TIMER_ENABLE: reg_enable = data[0];
            REG_CLOCK_SELECT: reg_select = data[1:0];
            REG_RELOAD_VALUE: reg_reload = data;
            default: ;
        endcase
    endtask

    // Offer one request after a random gap and record what it should return.
    task automatic send_request(input logic [7:0] cycles, input logic typed,
                                input timer_result_t typed_want);
        int            gap;
        timer_result_t res;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cycle_count <= cycles;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_timer(cycles, res);
        pending_results.push_back(typed ? typed_want : res);
    endtask

    // Stop offering and wait until every outstanding request has returned.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, field, got, want);
    endtask

    // Result side: random stalls, two long hold-offs, field-by-field checks.
    initial
    begin : result_side
        int            hold;
        timer_result_t want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (results_seen == 250 || results_seen == 1000)
                hold = 400;
            else
                hold = $urandom_range(0, stall_max);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request pending", timer_count, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (divider_value !== want.div_hi)
                    report_mismatch("divider_value", divider_value, want.div_hi);
                if (divider_low !== want.div_lo)
                    report_mismatch("divider_low", divider_low, want.div_lo);
                if (timer_count !== want.count)
                    report_mismatch("timer_count", timer_count, want.count);
                if (interrupt_raised !== want.irq)
                    report_mismatch("interrupt_raised", interrupt_raised, want.irq);
            end
        end
    end

    // Request side: reset, directed plan, then random phases.
    initial
    begin : request_side
        int         row;
        int         rep;
        int         sent;
        int         phase_len;
        int         k;
        logic       fine_steps;
        logic [7:0] value;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PLAN_ROWS; row++)
        begin
            if (plan[row].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[row].index, plan[row].data);
            end
            else
            begin
                for (rep = 0; rep < plan[row].reps; rep++)
                    send_request(plan[row].data, plan[row].typed, plan[row].want);
            end
        end

        // Each phase waits for the block to empty, then picks a new setting.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            value = 8'($urandom_range(0, 255));
            value[0] = ($urandom_range(0, 7) != 0);
            write_reg(REG_TIMER_ENABLE, value);
            write_reg(REG_CLOCK_SELECT, 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
                0: value = 8'h00;
                1: value = 8'hFF;
                2: value = 8'($urandom_range(0, 255));
                default: value = 8'($urandom_range(8'hF0, 8'hFF));
            endcase
            write_reg(REG_RELOAD_VALUE, value);

            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
            stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
            fine_steps = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 60);
            for (k = 0; k < phase_len; k++)
            begin
                case ($urandom_range(0, 7))
                    0: value = 8'h00;
                    1: value = 8'hFF;
                    default: value = fine_steps ? 8'($urandom_range(0, 15))
                                                : 8'($urandom_range(0, 255));
                endcase
                send_request(value, 1'b0, '0);
                sent++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("handheld_console_timer_tb: PASS");
        else
            $display("handheld_console_timer_tb: FAIL");
        $finish;
    end

endmodule
